[hdl/rep_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rep_pkg
// Shared types, codes and constants of the RESP element parser.
// ---------------------------------------------------------------------------
package rep_pkg;

	localparam int LEN_WIDTH_DEF = 30;
	localparam int SIMPLE_W      = 16;
	localparam int CFG_LEN_W     = 30;
	localparam int CFG_DATA_W    = 30;
	localparam int CFG_IDX_W     = 2;
	localparam int ACC_W         = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIMPLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ARRAY  = 2'd2;

	localparam logic [SIMPLE_W-1:0]  RST_MAX_SIMPLE = 16'd255;
	localparam logic [CFG_LEN_W-1:0] RST_MAX_BULK   = 30'd536870912;
	localparam logic [CFG_LEN_W-1:0] RST_MAX_ARRAY  = 30'd67108864;

	localparam logic [1:0] RK_PAYLOAD = 2'd0;
	localparam logic [1:0] RK_DONE    = 2'd1;
	localparam logic [1:0] RK_ERROR   = 2'd2;

	localparam logic [2:0] K_SIMPLE = 3'd0;
	localparam logic [2:0] K_ERROR  = 3'd1;
	localparam logic [2:0] K_INT    = 3'd2;
	localparam logic [2:0] K_BULK   = 3'd3;
	localparam logic [2:0] K_NIL    = 3'd4;
	localparam logic [2:0] K_ARRAY  = 3'd5;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERSIZE = 2'd1;
	localparam logic [1:0] ERR_INVALID  = 2'd2;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [ACC_W-1:0] INT_POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0] INT_NEG_LIM = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STR,
		PH_NUM,
		PH_PAYLOAD,
		PH_TRAILER
	} phase_t;

	typedef struct packed {
		logic [SIMPLE_W-1:0]  max_simple;
		logic [CFG_LEN_W-1:0] max_bulk;
		logic [CFG_LEN_W-1:0] max_array;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [2:0]       elem_kind;
		logic [ACC_W-1:0] value;
		logic [1:0]       err;
	} result_t;

endpackage
`default_nettype wire

[hdl/rep_cfg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rep_cfg
// Configuration registers: length limits written through the plain write port.
// ---------------------------------------------------------------------------
module rep_cfg
	import rep_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_simple <= RST_MAX_SIMPLE;
			cfg_q.max_bulk   <= RST_MAX_BULK;
			cfg_q.max_array  <= RST_MAX_ARRAY;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_SIMPLE: cfg_q.max_simple <= cfg_data[SIMPLE_W-1:0];
				REG_MAX_BULK:   cfg_q.max_bulk   <= cfg_data[CFG_LEN_W-1:0];
				REG_MAX_ARRAY:  cfg_q.max_array  <= cfg_data[CFG_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hdl/rep_in_stage.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rep_in_stage
// Input register: holds one stream byte until the parser takes it.
// ---------------------------------------------------------------------------
module rep_in_stage
	import rep_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            in_stall,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

[hdl/rep_parse.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rep_parse
// Element state and the per-byte parse step: type, number, content, trailer.
// ---------------------------------------------------------------------------
module rep_parse
	import rep_pkg::*;
#(
	parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       step,
	input  wire logic [7:0] byte_s1,
	output logic            emits,
	output result_t         res
);

	localparam logic [ACC_W-1:0] LEN_MAX64 = (64'd1 << LEN_WIDTH) - 64'd1;

	phase_t                 phase_q, phase_d;
	logic [2:0]             kind_q, kind_d;
	logic [ACC_W-1:0]       acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic                   seen_q, seen_d;
	logic [LEN_WIDTH-1:0]   count_q, count_d;
	logic [LEN_WIDTH-1:0]   remain_q, remain_d;
	logic                   held_cr_q, held_cr_d;

	logic [ACC_W-1:0]       cap_simple, cap_bulk, cap_array, num_lim, signed_val;
	logic [ACC_W+3:0]       acc_x10, acc_next;
	logic                   num_over, is_digit, do_clear;
	logic [LEN_WIDTH-1:0]   count_inc, remain_dec;

	always_comb begin
		cap_simple = (64'(cfg.max_simple) > LEN_MAX64) ? LEN_MAX64 : 64'(cfg.max_simple);
		cap_bulk   = (64'(cfg.max_bulk) > LEN_MAX64) ? LEN_MAX64 : 64'(cfg.max_bulk);
		cap_array  = (64'(cfg.max_array) > LEN_MAX64) ? LEN_MAX64 : 64'(cfg.max_array);
		if (kind_q == K_INT) begin
			num_lim = neg_q ? INT_NEG_LIM : INT_POS_LIM;
		end else if (neg_q) begin
			num_lim = 64'd1;
		end else begin
			num_lim = (kind_q == K_BULK) ? cap_bulk : cap_array;
		end
		acc_x10    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1);
		acc_next   = acc_x10 + 68'(byte_s1[3:0]);
		// Checking the full product covers both the pre-digit and post-digit bounds.
		num_over   = acc_next > {4'b0, num_lim};
		is_digit   = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		signed_val = neg_q ? (64'd0 - acc_q) : acc_q;
		count_inc  = count_q + 1'b1;
		remain_dec = remain_q - 1'b1;
	end

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		count_d   = count_q;
		remain_d  = remain_q;
		held_cr_d = held_cr_q;
		emits     = 1'b0;
		res       = '0;
		do_clear  = 1'b0;

		if (held_cr_q) begin
			if (byte_s1 != CH_LF) begin
				emits     = 1'b1;
				res.kind  = RK_ERROR;
				res.elem_kind = kind_q;
				res.err   = ERR_INVALID;
				do_clear  = 1'b1;
			end else if (phase_q == PH_NUM) begin
				if (kind_q == K_BULK) begin
					if (neg_q && (acc_q != '0)) begin
						emits         = 1'b1;
						res.kind      = RK_DONE;
						res.elem_kind = K_NIL;
						res.value     = '1;
						do_clear      = 1'b1;
					end else begin
						count_d   = acc_q[LEN_WIDTH-1:0];
						remain_d  = acc_q[LEN_WIDTH-1:0];
						held_cr_d = 1'b0;
						phase_d   = (acc_q == '0) ? PH_TRAILER : PH_PAYLOAD;
					end
				end else begin
					emits         = 1'b1;
					res.kind      = RK_DONE;
					res.elem_kind = kind_q;
					res.value     = signed_val;
					do_clear      = 1'b1;
				end
			end else begin
				emits         = 1'b1;
				res.kind      = RK_DONE;
				res.elem_kind = kind_q;
				res.value     = 64'(count_q);
				do_clear      = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					kind_d    = K_SIMPLE;
					acc_d     = '0;
					neg_d     = 1'b0;
					seen_d    = 1'b0;
					count_d   = '0;
					remain_d  = '0;
					held_cr_d = 1'b0;
					unique case (byte_s1)
						CH_PLUS: begin
							kind_d  = K_SIMPLE;
							phase_d = PH_STR;
						end
						CH_MINUS: begin
							kind_d  = K_ERROR;
							phase_d = PH_STR;
						end
						CH_COLON: begin
							kind_d  = K_INT;
							phase_d = PH_NUM;
						end
						CH_DOLLAR: begin
							kind_d  = K_BULK;
							phase_d = PH_NUM;
						end
						CH_STAR: begin
							kind_d  = K_ARRAY;
							phase_d = PH_NUM;
						end
						default: begin
							emits         = 1'b1;
							res.kind      = RK_ERROR;
							res.elem_kind = K_SIMPLE;
							res.err       = ERR_INVALID;
							do_clear      = 1'b1;
						end
					endcase
				end
				PH_STR: begin
					if (byte_s1 == CH_CR) begin
						held_cr_d = 1'b1;
					end else begin
						count_d = count_inc;
						emits   = 1'b1;
						res.elem_kind = kind_q;
						if ((64'(count_inc) > cap_simple) || (count_inc == '0)) begin
							res.kind = RK_ERROR;
							res.err  = ERR_OVERSIZE;
							do_clear = 1'b1;
						end else begin
							res.kind = RK_PAYLOAD;
							res.data = byte_s1;
						end
					end
				end
				PH_NUM: begin
					if ((byte_s1 == CH_MINUS) && !seen_q && !neg_q) begin
						neg_d = 1'b1;
					end else if (is_digit) begin
						if (num_over) begin
							emits         = 1'b1;
							res.kind      = RK_ERROR;
							res.elem_kind = kind_q;
							res.err       = ERR_OVERSIZE;
							do_clear      = 1'b1;
						end else begin
							acc_d  = acc_next[ACC_W-1:0];
							seen_d = 1'b1;
						end
					end else if ((byte_s1 == CH_CR) && seen_q) begin
						held_cr_d = 1'b1;
					end else begin
						emits         = 1'b1;
						res.kind      = RK_ERROR;
						res.elem_kind = kind_q;
						res.err       = ERR_INVALID;
						do_clear      = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						phase_d = PH_TRAILER;
					end
					emits         = 1'b1;
					res.kind      = RK_PAYLOAD;
					res.data      = byte_s1;
					res.elem_kind = K_BULK;
				end
				PH_TRAILER: begin
					if (byte_s1 == CH_CR) begin
						held_cr_d = 1'b1;
					end else begin
						emits         = 1'b1;
						res.kind      = RK_ERROR;
						res.elem_kind = kind_q;
						res.err       = ERR_INVALID;
						do_clear      = 1'b1;
					end
				end
				default: begin
					do_clear = 1'b1;
				end
			endcase
		end

		if (do_clear) begin
			phase_d   = PH_IDLE;
			kind_d    = K_SIMPLE;
			acc_d     = '0;
			neg_d     = 1'b0;
			seen_d    = 1'b0;
			count_d   = '0;
			remain_d  = '0;
			held_cr_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			kind_q    <= K_SIMPLE;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			count_q   <= '0;
			remain_q  <= '0;
			held_cr_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			acc_q     <= acc_d;
			neg_q     <= neg_d;
			seen_q    <= seen_d;
			count_q   <= count_d;
			remain_q  <= remain_d;
			held_cr_q <= held_cr_d;
		end
	end

`ifndef SYNTHESIS
	a_cr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		held_cr_q |-> (phase_q == PH_STR || phase_q == PH_NUM || phase_q == PH_TRAILER))
		else $error("held CR outside a line-ending phase");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remain_q != '0)
		else $error("payload phase with nothing remaining");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (!held_cr_q && !neg_q && !seen_q && acc_q == '0))
		else $error("idle with element state left over");

	a_error_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emits && res.kind == RK_ERROR) |=> (phase_q == PH_IDLE && !held_cr_q))
		else $error("error did not return the parser to idle");
`endif

endmodule
`default_nettype wire

[hdl/rep_out_stage.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rep_out_stage
// Result register: holds one result until the consumer takes the transfer.
// ---------------------------------------------------------------------------
module rep_out_stage
	import rep_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res_in,
	input  wire logic    out_stall,
	output logic         out_valid,
	output result_t      res_out
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule
`default_nettype wire

[hdl/resp_element_parser_core.sv]
`default_nettype none
// A result enters the result register when the parse step takes its byte from the input
// register. Throughput: one byte per cycle unless a new result meets a full, stalled output;
// the parse step updates all element state between the input and result registers.
// A byte that yields no result leaves the result register free for the next one.
// Reset is asynchronous: parser idle, no result pending, limit registers at their defaults.
// ---------------------------------------------------------------------------
// resp_element_parser_core
// Byte-serial RESP element parser with input and result registers.
// ---------------------------------------------------------------------------
module resp_element_parser_core
	import rep_pkg::*;
#(
	parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            in_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 result_kind,
	output logic [7:0]                 data_byte,
	output logic [2:0]                 elem_kind,
	output logic signed [63:0]         elem_value,
	output logic [1:0]                 error_code
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance, step, emits, load;
	result_t    res, res_out;

	assign advance = !emits || !out_valid || !out_stall;
	assign step    = valid_s1 && advance;
	assign load    = step && emits;

	rep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rep_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_stall (in_stall),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rep_parse #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.byte_s1 (byte_s1),
		.emits   (emits),
		.res     (res)
	);

	rep_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_in    (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign result_kind = res_out.kind;
	assign data_byte   = res_out.data;
	assign elem_kind   = res_out.elem_kind;
	assign elem_value  = res_out.value;
	assign error_code  = res_out.err;

endmodule
`default_nettype wire

[verif/resp_result_check.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// resp_result_check
// Watches the byte and result channels and the limit writes of the RESP
// element parser. It keeps its own byte-serial parser state and limits,
// works out the results of every byte transfer, and compares each result
// transfer field by field with the oldest outstanding result. It hands the
// number of mismatches, the number of outstanding results and whether its
// parser state sits between elements to the testbench top.
// ---------------------------------------------------------------------------
module resp_result_check
	import rep_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [1:0]            result_kind,
	input  wire logic [7:0]            data_byte,
	input  wire logic [2:0]            elem_kind,
	input  wire logic signed [63:0]    elem_value,
	input  wire logic [1:0]            error_code,
	output int                         mismatches,
	output int                         awaited,
	output logic                       between_elements
);

	logic [SIMPLE_W-1:0]  lim_simple;
	logic [CFG_LEN_W-1:0] lim_bulk;
	logic [CFG_LEN_W-1:0] lim_array;

	phase_t               ph;
	logic [2:0]           kind_now;
	logic [ACC_W-1:0]     magnitude;
	logic                 minus;
	logic                 have_digit;
	logic                 cr_pending;
	logic [CFG_LEN_W-1:0] byte_count;
	logic [CFG_LEN_W-1:0] left_count;

	result_t awaited_q[$];

	task automatic clear_elem();
		ph = PH_IDLE;
		kind_now = K_SIMPLE;
		magnitude = '0;
		minus = 1'b0;
		have_digit = 1'b0;
		cr_pending = 1'b0;
		byte_count = '0;
		left_count = '0;
	endtask

	task automatic queue_result(input logic [1:0] rk, input logic [7:0] d, input logic [2:0] ek,
			input logic [63:0] v, input logic [1:0] e);
		result_t r;
		r.kind = rk;
		r.data = d;
		r.elem_kind = ek;
		r.value = v;
		r.err = e;
		awaited_q.push_back(r);
	endtask

	task automatic abort_elem(input logic [1:0] code);
		logic [2:0] k;
		k = kind_now;
		clear_elem();
		queue_result(RK_ERROR, 8'd0, k, 64'd0, code);
	endtask

	function automatic logic [63:0] digit_limit();
		if (kind_now == K_INT) begin
			return minus ? INT_NEG_LIM : INT_POS_LIM;
		end
		if (minus) begin
			return 64'd1;
		end
		return (kind_now == K_BULK) ? 64'(lim_bulk) : 64'(lim_array);
	endfunction

	task automatic end_number_line();
		logic [2:0]  k;
		logic [63:0] v;
		k = kind_now;
		v = minus ? (64'd0 - magnitude) : magnitude;
		if (k == K_BULK) begin
			if (minus && magnitude != 0) begin
				clear_elem();
				queue_result(RK_DONE, 8'd0, K_NIL, '1, ERR_NONE);
			end else begin
				byte_count = magnitude[CFG_LEN_W-1:0];
				left_count = magnitude[CFG_LEN_W-1:0];
				cr_pending = 1'b0;
				ph = (magnitude == 0) ? PH_TRAILER : PH_PAYLOAD;
			end
		end else begin
			clear_elem();
			queue_result(RK_DONE, 8'd0, k, v, ERR_NONE);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [63:0]          lim;
		logic [63:0]          grown;
		logic [2:0]           k;
		logic [CFG_LEN_W-1:0] n;
		if (cr_pending) begin
			if (b != CH_LF) begin
				abort_elem(ERR_INVALID);
			end else begin
				cr_pending = 1'b0;
				if (ph == PH_NUM) begin
					end_number_line();
				end else begin
					k = kind_now;
					n = byte_count;
					clear_elem();
					queue_result(RK_DONE, 8'd0, k, 64'(n), ERR_NONE);
				end
			end
		end else begin
			case (ph)
				PH_IDLE: begin
					clear_elem();
					case (b)
						CH_PLUS: begin
							kind_now = K_SIMPLE;
							ph = PH_STR;
						end
						CH_MINUS: begin
							kind_now = K_ERROR;
							ph = PH_STR;
						end
						CH_COLON: begin
							kind_now = K_INT;
							ph = PH_NUM;
						end
						CH_DOLLAR: begin
							kind_now = K_BULK;
							ph = PH_NUM;
						end
						CH_STAR: begin
							kind_now = K_ARRAY;
							ph = PH_NUM;
						end
						default: abort_elem(ERR_INVALID);
					endcase
				end
				PH_STR: begin
					if (b == CH_CR) begin
						cr_pending = 1'b1;
					end else begin
						byte_count = byte_count + 1'b1;
						if (byte_count > lim_simple || byte_count == 0) begin
							abort_elem(ERR_OVERSIZE);
						end else begin
							queue_result(RK_PAYLOAD, b, kind_now, 64'd0, ERR_NONE);
						end
					end
				end
				PH_NUM: begin
					if (b == CH_MINUS && !have_digit && !minus) begin
						minus = 1'b1;
					end else if (b >= CH_ZERO && b <= CH_NINE) begin
						lim = digit_limit();
						if (magnitude > lim / 64'd10) begin
							abort_elem(ERR_OVERSIZE);
						end else begin
							grown = magnitude * 64'd10 + 64'(b - CH_ZERO);
							if (grown > lim) begin
								abort_elem(ERR_OVERSIZE);
							end else begin
								magnitude = grown;
								have_digit = 1'b1;
							end
						end
					end else if (b == CH_CR && have_digit) begin
						cr_pending = 1'b1;
					end else begin
						abort_elem(ERR_INVALID);
					end
				end
				PH_PAYLOAD: begin
					left_count = left_count - 1'b1;
					if (left_count == 0) begin
						ph = PH_TRAILER;
					end
					queue_result(RK_PAYLOAD, b, K_BULK, 64'd0, ERR_NONE);
				end
				PH_TRAILER: begin
					if (b == CH_CR) begin
						cr_pending = 1'b1;
					end else begin
						abort_elem(ERR_INVALID);
					end
				end
				default: clear_elem();
			endcase
		end
	endtask

	task automatic compare_field(input string field, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (awaited_q.size() == 0) begin
			$display("%0t: result with none expected: kind %0d data %h elem %0d value %0d error %0d",
				$time, result_kind, data_byte, elem_kind, elem_value, error_code);
			mismatches++;
		end else begin
			want = awaited_q.pop_front();
			compare_field("result_kind", 64'(want.kind), 64'(result_kind));
			compare_field("data_byte", 64'(want.data), 64'(data_byte));
			compare_field("elem_kind", 64'(want.elem_kind), 64'(elem_kind));
			compare_field("elem_value", want.value, elem_value);
			compare_field("error_code", 64'(want.err), 64'(error_code));
		end
	endtask

	// Results are checked before the byte of the same edge is parsed, so a
	// spurious result can never be matched by a prediction made in that cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_simple = RST_MAX_SIMPLE;
			lim_bulk = RST_MAX_BULK;
			lim_array = RST_MAX_ARRAY;
			clear_elem();
			awaited_q.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_MAX_SIMPLE: lim_simple = cfg_data[SIMPLE_W-1:0];
					REG_MAX_BULK:   lim_bulk = cfg_data[CFG_LEN_W-1:0];
					REG_MAX_ARRAY:  lim_array = cfg_data[CFG_LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				parse_byte(in_byte);
			end
		end
		awaited = awaited_q.size();
		between_elements = (ph == PH_IDLE) && !cr_pending;
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives a RESP byte stream into the element parser: a short directed
// stream with the edge cases, then random elements of every kind, mostly
// well formed with random content, mixed with malformed numbers, broken
// line ends and stray bytes. The limits are changed between runs, the
// extremes among them, and both channels pause at random. The result check
// beside the parser predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench
	import rep_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEM_TOTAL     = 1250;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic [7:0]            in_byte = '0;
	logic                  out_stall = 1'b0;

	logic                  in_stall;
	logic                  out_valid;
	logic [1:0]            result_kind;
	logic [7:0]            data_byte;
	logic [2:0]            elem_kind;
	logic signed [63:0]    elem_value;
	logic [1:0]            error_code;

	int                    mismatches;
	int                    awaited;
	logic                  between_elements;

	int                    send_idle_pct = 18;
	int                    recv_idle_pct = 83;
	int                    bytes_sent = 0;
	int                    quiet_cycles = 0;
	logic [SIMPLE_W-1:0]   simple_cap = RST_MAX_SIMPLE;
	logic [CFG_LEN_W-1:0]  bulk_cap = RST_MAX_BULK;
	logic [CFG_LEN_W-1:0]  array_cap = RST_MAX_ARRAY;

	always #5 clk = ~clk;

	resp_element_parser_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.data_byte   (data_byte),
		.elem_kind   (elem_kind),
		.elem_value  (elem_value),
		.error_code  (error_code)
	);

	resp_result_check result_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.data_byte        (data_byte),
		.elem_kind        (elem_kind),
		.elem_value       (elem_value),
		.error_code       (error_code),
		.mismatches       (mismatches),
		.awaited          (awaited),
		.between_elements (between_elements)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// Holds the sender until every outstanding result has been transferred
	// and the parser pipeline has run empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic settle();
		drain();
		while (!between_elements) begin
			send_byte(CH_CR);
			drain();
		end
	endtask

	task automatic set_limits(input logic [SIMPLE_W-1:0] s, input logic [CFG_LEN_W-1:0] bk,
			input logic [CFG_LEN_W-1:0] ar);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= REG_MAX_SIMPLE;
		cfg_data <= CFG_DATA_W'(s);
		@(posedge clk);
		cfg_index <= REG_MAX_BULK;
		cfg_data <= bk;
		@(posedge clk);
		cfg_index <= REG_MAX_ARRAY;
		cfg_data <= ar;
		@(posedge clk);
		cfg_write <= 1'b0;
		simple_cap = s;
		bulk_cap = bk;
		array_cap = ar;
	endtask

	function automatic logic [7:0] byte_except(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == avoid) begin
			b = ~avoid;
		end
		return b;
	endfunction

	function automatic string number_text(input bit neg, input logic [63:0] mag);
		string t;
		t = $sformatf("%0d", mag);
		if ($urandom_range(0, 7) == 0) begin
			t = {"0", t};
		end
		if (neg) begin
			t = {"-", t};
		end
		return t;
	endfunction

	task automatic send_line_end(output bit ok);
		send_byte(CH_CR);
		ok = ($urandom_range(0, 24) != 0);
		send_byte(ok ? CH_LF : byte_except(CH_LF));
	endtask

	task automatic send_string_elem(input logic [7:0] type_ch);
		int n;
		bit ok;
		case ($urandom_range(0, 5))
			0: n = int'(simple_cap);
			1: n = int'(simple_cap) + 1;
			default: n = $urandom_range(0, 6);
		endcase
		if (n > 40) begin
			n = $urandom_range(0, 6);
		end
		send_byte(type_ch);
		repeat (n) send_byte(byte_except(CH_CR));
		send_line_end(ok);
	endtask

	task automatic send_int_elem();
		logic [63:0] mag;
		bit          neg;
		bit          ok;
		string       t;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: begin
				neg = 1'b0;
				mag = INT_POS_LIM;
			end
			1: begin
				neg = 1'b1;
				mag = INT_NEG_LIM;
			end
			2: begin
				neg = 1'b0;
				mag = INT_POS_LIM + 64'd1;
			end
			3: begin
				neg = 1'b1;
				mag = INT_NEG_LIM + 64'd1;
			end
			4: mag = '0;
			5: mag = {$urandom, $urandom};
			6: mag = 64'($urandom_range(0, 999));
			default: mag = 64'($urandom);
		endcase
		t = number_text(neg, mag);
		if ($urandom_range(0, 9) == 0) begin
			t = $sformatf("%s%0d", t, $urandom_range(0, 9));
		end
		send_byte(CH_COLON);
		send_text(t);
		send_line_end(ok);
	endtask

	task automatic send_count_elem(input bit bulk);
		logic [63:0] cap;
		logic [63:0] mag;
		bit          neg;
		bit          ok;
		cap = bulk ? 64'(bulk_cap) : 64'(array_cap);
		neg = 1'b0;
		case ($urandom_range(0, 9))
			0: mag = cap;
			1: mag = cap + 64'd1;
			2: begin
				neg = 1'b1;
				mag = '0;
			end
			3: begin
				neg = 1'b1;
				mag = 64'd1;
			end
			4: begin
				neg = 1'b1;
				mag = 64'($urandom_range(2, 99));
			end
			5: mag = {$urandom, $urandom};
			default: mag = 64'($urandom_range(0, 8));
		endcase
		if (bulk && !neg && mag <= cap && mag > 16) begin
			mag = 64'($urandom_range(0, 8));
		end
		send_byte(bulk ? CH_DOLLAR : CH_STAR);
		send_text(number_text(neg, mag));
		send_line_end(ok);
		if (bulk && ok && (neg ? (mag == 0) : (mag <= cap))) begin
			repeat (mag) send_byte(8'($urandom_range(0, 255)));
			case ($urandom_range(0, 11))
				0: send_byte(byte_except(CH_CR));
				1: begin
					send_byte(CH_CR);
					send_byte(byte_except(CH_LF));
				end
				default: begin
					send_byte(CH_CR);
					send_byte(CH_LF);
				end
			endcase
		end
	endtask

	task automatic send_bad_number();
		logic [7:0] b;
		case ($urandom_range(0, 2))
			0: send_byte(CH_COLON);
			1: send_byte(CH_DOLLAR);
			default: send_byte(CH_STAR);
		endcase
		case ($urandom_range(0, 4))
			0: ;
			1: send_byte(CH_MINUS);
			2: begin
				send_text("12");
				send_byte(CH_MINUS);
				send_text("1");
			end
			3: send_text("--1");
			default: begin
				b = 8'($urandom_range(0, 255));
				if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR || b == CH_MINUS) begin
					b = CH_PLUS;
				end
				send_text("12");
				send_byte(b);
			end
		endcase
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_random_elem();
		case ($urandom_range(0, 19))
			0, 1, 2:         send_string_elem(CH_PLUS);
			3, 4:            send_string_elem(CH_MINUS);
			5, 6, 7, 8:      send_int_elem();
			9, 10, 11, 12:   send_count_elem(1'b1);
			13, 14, 15:      send_count_elem(1'b0);
			16, 17:          send_bad_number();
			18:              repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			default:         drain();
		endcase
	endtask

	task automatic run_until(input int goal);
		while (bytes_sent < goal) begin
			send_random_elem();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(CH_PLUS);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("\r\n");
		send_text(":-0\r\n");
		send_text("$-1\r\n");
		send_text("*2\r\n");
		send_byte(8'hFF);
		send_text("-e\rx");
		send_text("$1\r\nab");

		set_limits(16'hFFFF, '0, '1);
		run_until(ITEM_TOTAL / 3);

		send_idle_pct = 83;
		recv_idle_pct = 18;
		set_limits(16'd1, '1, '0);
		run_until(2 * ITEM_TOTAL / 3);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(SIMPLE_W'($urandom_range(2, 12)), CFG_LEN_W'($urandom_range(0, 12)),
			CFG_LEN_W'($urandom_range(0, 5000)));
		run_until(ITEM_TOTAL);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
